[src/bsa_pkg.sv]
// Package for the bitmap slot allocator: command and status codes and the
// fixed widths of the item fields. No dependencies.
package bsa_pkg;

  typedef enum logic [1:0] {
    CMD_ALLOC_ONE = 2'd0,
    CMD_ALLOC_TWO = 2'd1,
    CMD_FREE_ONE  = 2'd2,
    CMD_FREE_TWO  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_BAD_FREE = 2'd2
  } status_e;

  localparam int unsigned FreeSlotW = 4;
  localparam int unsigned SlotW     = 3;
  localparam int unsigned OffsetW   = 7;
  localparam int unsigned OccW      = 8;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 24;

endpackage

[src/bsa_find.sv]
// First-fit search over the occupancy map: lowest free slot and lowest free
// pair of adjacent slots. Uses no package items.
module bsa_find #(
  parameter int unsigned SLOTS = 8,
  parameter int unsigned IDX_W = $clog2(SLOTS)
) (
  input  logic [SLOTS-1:0] map_i,
  output logic             one_found_o,
  output logic [IDX_W-1:0] one_idx_o,
  output logic             two_found_o,
  output logic [IDX_W-1:0] two_idx_o
);

  logic [SLOTS-1:0] free_one;
  logic [SLOTS-1:0] free_two;
  logic [SLOTS-1:0] low_one;
  logic [SLOTS-1:0] low_two;

  always_comb begin
    free_one = ~map_i;
    free_two = '0;
    for (int i = 0; i < int'(SLOTS) - 1; i++) begin
      free_two[i] = free_one[i] & free_one[i+1];
    end
  end

  // Isolate the lowest set bit of each candidate vector.
  assign low_one = free_one & (~free_one + SLOTS'(1));
  assign low_two = free_two & (~free_two + SLOTS'(1));

  assign one_found_o = |free_one;
  assign two_found_o = |free_two;

  // Encode the one-hot position.
  always_comb begin
    one_idx_o = '0;
    two_idx_o = '0;
    for (int i = 0; i < int'(SLOTS); i++) begin
      if (low_one[i]) begin
        one_idx_o = one_idx_o | IDX_W'(i);
      end
      if (low_two[i]) begin
        two_idx_o = two_idx_o | IDX_W'(i);
      end
    end
  end

endmodule

[src/bitmap_slot_allocator_top.sv]
// Top level of the bitmap slot allocator: input register, first-fit search,
// map update and result register. Depends on bsa_pkg and bsa_find.
//
// The block keeps a used/free bitmap over SLOTS slots of SLOT_BYTES bytes each
// and handles one command per item: allocate one slot, allocate two adjacent
// slots (lowest fitting position first), free one slot or free two adjacent
// slots. Each command returns exactly one result with the grant flag, the
// first slot, its byte offset (low 7 bits), a status and the bitmap after the
// command. The block takes one item per cycle while the output is not stalled.
// A result is presented once its item has passed through the input register
// and then the result register. A stalled result holds the next item in the
// input register. The map is updated in the same cycle the item moves into
// the result register, so back-to-back commands always see the map left by
// the one before. The map resets to all free.
module bitmap_slot_allocator_top #(
  parameter int unsigned SLOTS      = 8,
  parameter int unsigned SLOT_BYTES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [3:0] free_slot, [7:4] zero
  input  logic [bsa_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [1:0] cmd
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] granted, [3:1] slot, [10:4] byte_offset, [12:11] status,
  // [20:13] occupancy, [23:21] zero
  output logic [bsa_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam logic [6:0] SlotsW7 = 7'(SLOTS);
  localparam logic [bsa_pkg::OffsetW-1:0] BytesLo =
    bsa_pkg::OffsetW'(SLOT_BYTES % 128);

  // Input register
  logic                             in_vld_q;
  bsa_pkg::cmd_e                    cmd_q;
  logic [bsa_pkg::FreeSlotW-1:0]    fs_q;

  // Occupancy map
  logic [SLOTS-1:0]                 map_q, map_d;

  // Result register
  logic                             out_vld_q;
  logic                             granted_q, granted_d;
  logic [bsa_pkg::SlotW-1:0]        slot_q, slot_d;
  logic [bsa_pkg::OffsetW-1:0]      offset_q, offset_d;
  bsa_pkg::status_e                 status_q, status_d;
  logic [bsa_pkg::OccW-1:0]         occ_q, occ_d;

  logic                             advance;
  logic                             one_found, two_found;
  logic [IdxW-1:0]                  one_idx, two_idx;
  logic [IdxW-1:0]                  grant_idx;
  logic [6:0]                       fs_w7;
  logic [SLOTS-1:0]                 clr_mask;
  logic [SLOTS-1:0]                 set_mask;

  // Move the held item into the result register when that register is free or is being read out.
  assign advance         = in_vld_q & (~out_vld_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_vld_q | advance;

  bsa_find #(
    .SLOTS (SLOTS),
    .IDX_W (IdxW)
  ) u_find (
    .map_i       (map_q),
    .one_found_o (one_found),
    .one_idx_o   (one_idx),
    .two_found_o (two_found),
    .two_idx_o   (two_idx)
  );

  assign fs_w7 = 7'(fs_q);

  // Build set and clear masks for the current command.
  always_comb begin
    set_mask = '0;
    clr_mask = '0;
    grant_idx = (cmd_q == bsa_pkg::CMD_ALLOC_TWO) ? two_idx : one_idx;
    for (int i = 0; i < int'(SLOTS); i++) begin
      if (7'(i) == fs_w7) begin
        clr_mask[i] = 1'b1;
      end
      if ((cmd_q == bsa_pkg::CMD_FREE_TWO) && (7'(i) == fs_w7 + 7'd1)) begin
        clr_mask[i] = 1'b1;
      end
      if (IdxW'(i) == grant_idx) begin
        set_mask[i] = 1'b1;
      end
      if ((cmd_q == bsa_pkg::CMD_ALLOC_TWO) && (i > 0) && (IdxW'(i - 1) == grant_idx)) begin
        set_mask[i] = 1'b1;
      end
    end
  end

  always_comb begin
    map_d     = map_q;
    granted_d = 1'b0;
    slot_d    = '0;
    offset_d  = '0;
    status_d  = bsa_pkg::STAT_DONE;
    case (cmd_q)
      bsa_pkg::CMD_ALLOC_ONE, bsa_pkg::CMD_ALLOC_TWO: begin
        if ((cmd_q == bsa_pkg::CMD_ALLOC_ONE) ? one_found : two_found) begin
          map_d     = map_q | set_mask;
          granted_d = 1'b1;
          slot_d    = bsa_pkg::SlotW'(grant_idx);
          offset_d  = bsa_pkg::OffsetW'(7'(grant_idx) * BytesLo);
        end else begin
          status_d = bsa_pkg::STAT_NO_SPACE;
        end
      end
      bsa_pkg::CMD_FREE_ONE: begin
        if (fs_w7 >= SlotsW7) begin
          status_d = bsa_pkg::STAT_BAD_FREE;
        end else begin
          map_d = map_q & ~clr_mask;
        end
      end
      bsa_pkg::CMD_FREE_TWO: begin
        if (fs_w7 + 7'd1 >= SlotsW7) begin
          status_d = bsa_pkg::STAT_BAD_FREE;
        end else begin
          map_d = map_q & ~clr_mask;
        end
      end
      default: begin
        status_d = bsa_pkg::STAT_DONE;
      end
    endcase
    occ_d = bsa_pkg::OccW'(map_d);
  end

  // Control state and map.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      map_q     <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        map_q     <= map_d;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      cmd_q <= bsa_pkg::cmd_e'(s_axis_tuser_i);
      fs_q  <= s_axis_tdata_i[bsa_pkg::FreeSlotW-1:0];
    end
    if (advance) begin
      granted_q <= granted_d;
      slot_q    <= slot_d;
      offset_q  <= offset_d;
      status_q  <= status_d;
      occ_q     <= occ_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, occ_q, status_q, offset_q, slot_q, granted_q};

endmodule
